[hdl/ramped_gain_with_ducker_macros.svh]
`ifndef RAMPED_GAIN_WITH_DUCKER_MACROS_SVH
`define RAMPED_GAIN_WITH_DUCKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RGD_ASSERT_NOW(label, ck, rstn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RGD_ASSERT_NEXT(label, ck, rstn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/rgd_pkg.sv]
package rgd_pkg;

  // Fixed-point formats and limits.
  localparam int LINEAR_FRAC_BITS  = 12;
  localparam int MAX_BLOCK         = 4096;
  localparam int MUTE_LEVEL_DB     = -96;
  localparam int TABLE_ENTRIES_DEF = 961;
  localparam int DB_UNIT           = 65536;
  localparam int TABLE_ZERO_IDX    = 768;
  localparam int GAIN_MIN24        = -8388608;
  localparam int GAIN_MAX24        = 8388607;
  localparam int GAIN_SLOTS        = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Gain table clamp range and rounding offset to the nearest 1/8 dB.
  localparam logic signed [24:0] TOTAL_LO  = -25'sd6291456;
  localparam logic signed [24:0] TOTAL_HI  = 25'sd1572864;
  localparam logic signed [24:0] IDX_ROUND = 25'sd4096;

  // Mute target, saturated to the 24-bit gain range.
  localparam int MUTE_RAW = MUTE_LEVEL_DB * DB_UNIT;
  localparam int MUTE_SAT = (MUTE_RAW < GAIN_MIN24) ? GAIN_MIN24 :
                            ((MUTE_RAW > GAIN_MAX24) ? GAIN_MAX24 : MUTE_RAW);
  localparam logic signed [23:0] MUTE_TARGET = 24'(MUTE_SAT);

  // Register reset values.
  localparam logic [15:0] FADE_STEP_RST   = 16'd546;
  localparam logic [15:0] ATTACK_STEP_RST = 16'd164;
  localparam logic [15:0] DECAY_STEP_RST  = 16'd123;

  // Q28 constants for building the dB-to-linear table.
  localparam logic [63:0] Q28_ONE        = 64'd268435456;
  localparam logic [63:0] Q28_RATIO_UP   = 64'd272326484;
  localparam logic [63:0] Q28_RATIO_DOWN = 64'd264600024;
  localparam logic [63:0] Q28_CAP        = 64'd34359738368;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MANUAL_TARGET = 3'd0,
    CFG_DUCKER_TARGET = 3'd1,
    CFG_MUTE_ENABLE   = 3'd2,
    CFG_DUCK_BLOCK    = 3'd3,
    CFG_ADJUST_ENABLE = 3'd4,
    CFG_FADE_STEP     = 3'd5,
    CFG_ATTACK_STEP   = 3'd6,
    CFG_DECAY_STEP    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [23:0] manual_target_gain;
    logic signed [23:0] ducker_target_gain;
    logic               mute_enable;
    logic               duck_block;
    logic               adjust_enable;
    logic [15:0]        manual_fade_step;
    logic [15:0]        attack_step;
    logic [15:0]        decay_step;
  } cfg_t;

  typedef enum logic {
    GAIN_MANUAL = 1'b0,
    GAIN_DUCKER = 1'b1
  } gain_sel_t;

  typedef struct packed {
    logic               rd_en;
    gain_sel_t          rd_addr;
    logic               wr_en;
    gain_sel_t          wr_addr;
    logic signed [23:0] wr_data;
  } mem_req_t;

  typedef enum logic [3:0] {
    S_BOOT,
    S_BOOT_LD,
    S_IDLE,
    S_MAN,
    S_DUP,
    S_DUK,
    S_IDX,
    S_FAC,
    S_OUT
  } rgd_state_t;

endpackage

[hdl/rgd_stream_if.sv]
interface rgd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_in;
  logic               block_start;
  logic [12:0]        block_length;

  modport source (output valid, sample_in, block_start, block_length, input ready);
  modport sink (input valid, sample_in, block_start, block_length, output ready);
endinterface

interface rgd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;
  logic signed [24:0] total_gain;

  modport source (output valid, sample_out, total_gain, input ready);
  modport sink (input valid, sample_out, total_gain, output ready);
endinterface

[hdl/rgd_gain_mem.sv]
module rgd_gain_mem (
  input  logic                clk,
  input  logic                rst_n,
  input  rgd_pkg::mem_req_t   req,
  output logic signed [23:0]  gain_q
);

  logic signed [23:0]             gain_ram_r [rgd_pkg::GAIN_SLOTS];
  logic [rgd_pkg::GAIN_SLOTS-1:0] vld_r;
  logic signed [23:0]             rd_data_r;
  logic                           rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      gain_ram_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= gain_ram_r[req.rd_addr];
    end
  end

  // An entry never written reads as 0 dB.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  assign gain_q = rd_vld_r ? rd_data_r : '0;

endmodule

[hdl/rgd_db_rom.sv]
module rgd_db_rom #(
  parameter int TABLE_ENTRIES = rgd_pkg::TABLE_ENTRIES_DEF,
  localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [15:0]      rd_data_r
);

  // Rounds a Q28 value half up to the linear fraction width and saturates.
  function automatic logic [15:0] q28_to_word(logic [63:0] v);
    logic [63:0] w;
    w = (v + (64'd1 << (27 - rgd_pkg::LINEAR_FRAC_BITS))) >> (28 - rgd_pkg::LINEAR_FRAC_BITS);
    return (w > 64'd65535) ? 16'hFFFF : w[15:0];
  endfunction

  // Word k holds 10^((k/8 - 96)/20), built outward from the 0 dB entry.
  function automatic logic [TABLE_ENTRIES-1:0][15:0] build_rom();
    logic [TABLE_ENTRIES-1:0][15:0] t;
    logic [63:0]                    v;
    t = '0;
    v = rgd_pkg::Q28_ONE;
    for (int k = rgd_pkg::TABLE_ZERO_IDX; k < TABLE_ENTRIES; k++) begin
      if (k > rgd_pkg::TABLE_ZERO_IDX) begin
        v = (v * rgd_pkg::Q28_RATIO_UP + (rgd_pkg::Q28_ONE >> 1)) >> 28;
        if (v > rgd_pkg::Q28_CAP) begin
          v = rgd_pkg::Q28_CAP;
        end
      end
      t[k] = q28_to_word(v);
    end
    v = rgd_pkg::Q28_ONE;
    for (int k = rgd_pkg::TABLE_ZERO_IDX - 1; k >= 0; k--) begin
      v = (v * rgd_pkg::Q28_RATIO_DOWN + (rgd_pkg::Q28_ONE >> 1)) >> 28;
      if (k < TABLE_ENTRIES) begin
        t[k] = q28_to_word(v);
      end
    end
    return t;
  endfunction

  localparam logic [TABLE_ENTRIES-1:0][15:0] ROM_C = build_rom();

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ROM_C[rd_addr];
    end
  end

endmodule

[hdl/rgd_ctrl.sv]
`include "ramped_gain_with_ducker_macros.svh"

module rgd_ctrl #(
  parameter int TABLE_ENTRIES = rgd_pkg::TABLE_ENTRIES_DEF,
  localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rgd_pkg::cfg_t      cfg,
  rgd_in_if.sink             in_ch,
  rgd_out_if.source          out_ch,
  output rgd_pkg::mem_req_t  mem_req,
  input  logic signed [23:0] gain_q,
  output logic               rom_rd_en,
  output logic [IDX_W-1:0]   rom_addr,
  input  logic [15:0]        rom_q
);

  localparam int F = rgd_pkg::LINEAR_FRAC_BITS;
  localparam logic signed [33:0] SAT_HI   = 34'sd32767;
  localparam logic signed [33:0] SAT_LO   = -34'sd32768;
  localparam logic signed [33:0] RND_HALF = 34'sd1 <<< (F - 1);

  // Moves cur toward tgt by up or down and lands on tgt when within one step.
  function automatic logic signed [23:0] ramp(logic signed [23:0] cur,
                                             logic signed [23:0] tgt,
                                             logic [28:0] up, logic [28:0] down);
    logic signed [31:0] c, t, u, d, r;
    c = 32'(cur);
    t = 32'(tgt);
    u = signed'(32'(up));
    d = signed'(32'(down));
    if (c < t - u) begin
      r = c + u;
    end else if (c > t + d) begin
      r = c - d;
    end else begin
      r = t;
    end
    return r[23:0];
  endfunction

  rgd_pkg::rgd_state_t state_r, state_nxt;

  logic signed [15:0] sample_r, sample_nxt;
  logic [12:0]        len_r, len_nxt;
  logic [28:0]        step_a_r, step_a_nxt;
  logic [28:0]        step_b_r, step_b_nxt;
  logic signed [23:0] man_r, man_nxt;
  logic signed [24:0] total_r, total_nxt;
  logic [15:0]        factor_r, factor_nxt;
  logic signed [32:0] prod_r, prod_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] sample_out_r, sample_out_nxt;
  logic signed [24:0] total_gain_r, total_gain_nxt;

  logic [12:0]        len_in;
  logic [15:0]        coef_op;
  logic [12:0]        len_op;
  logic [28:0]        step_p;
  logic signed [15:0] samp_op;
  logic [15:0]        fac_op;
  logic signed [32:0] prod_p;
  logic signed [23:0] man_tgt, man_new, duck_new;
  logic signed [24:0] g_clamped;
  logic [22:0]        g_off;
  logic [9:0]         idx_raw;
  logic signed [33:0] rnd, shifted;
  logic               in_ready, out_load;

  assign len_in = (32'(in_ch.block_length) > rgd_pkg::MAX_BLOCK) ?
                  13'(rgd_pkg::MAX_BLOCK) : in_ch.block_length;

  // Shared step multiplier: fade step at accept, decay then attack after.
  always_comb begin
    case (state_r)
      rgd_pkg::S_IDLE: coef_op = cfg.manual_fade_step;
      rgd_pkg::S_MAN:  coef_op = cfg.decay_step;
      default:         coef_op = cfg.attack_step;
    endcase
  end
  assign len_op = (state_r == rgd_pkg::S_IDLE) ? len_in : len_r;
  assign step_p = 29'(coef_op) * 29'(len_op);

  // Shared sample multiplier: held factor for plain samples, fresh ROM word otherwise.
  assign samp_op = (state_r == rgd_pkg::S_IDLE) ? in_ch.sample_in : sample_r;
  assign fac_op  = (state_r == rgd_pkg::S_IDLE) ? factor_r : rom_q;
  assign prod_p  = 33'(samp_op) * 33'($signed({1'b0, fac_op}));

  // Gain updates.
  assign man_tgt = cfg.mute_enable ? rgd_pkg::MUTE_TARGET : $signed(cfg.manual_target_gain);
  assign man_new = ramp(gain_q, man_tgt, step_a_r, step_a_r);

  always_comb begin
    if (cfg.duck_block || cfg.mute_enable) begin
      duck_new = '0;
    end else if (cfg.adjust_enable) begin
      duck_new = ramp(gain_q, $signed(cfg.ducker_target_gain), step_b_r, step_a_r);
    end else begin
      duck_new = ramp(gain_q, '0, step_b_r, step_b_r);
    end
  end

  // Table index: clamp, offset and round to 1/8 dB.
  always_comb begin
    if (total_r < rgd_pkg::TOTAL_LO) begin
      g_clamped = rgd_pkg::TOTAL_LO;
    end else if (total_r > rgd_pkg::TOTAL_HI) begin
      g_clamped = rgd_pkg::TOTAL_HI;
    end else begin
      g_clamped = total_r;
    end
    g_off   = 23'(g_clamped - rgd_pkg::TOTAL_LO + rgd_pkg::IDX_ROUND);
    idx_raw = g_off[22:13];
    if (32'(idx_raw) > TABLE_ENTRIES - 1) begin
      rom_addr = IDX_W'(TABLE_ENTRIES - 1);
    end else begin
      rom_addr = IDX_W'(idx_raw);
    end
  end

  // Rounding half up, then saturation.
  assign rnd     = 34'(prod_r) + RND_HALF;
  assign shifted = rnd >>> F;

  assign out_load = (state_r == rgd_pkg::S_OUT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    rom_rd_en      = 1'b0;
    mem_req        = '0;
    sample_nxt     = sample_r;
    len_nxt        = len_r;
    step_a_nxt     = step_a_r;
    step_b_nxt     = step_b_r;
    man_nxt        = man_r;
    total_nxt      = total_r;
    factor_nxt     = factor_r;
    prod_nxt       = prod_r;
    sample_out_nxt = sample_out_r;
    total_gain_nxt = total_gain_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    case (state_r)
      rgd_pkg::S_BOOT: begin
        rom_rd_en = 1'b1;
        state_nxt = rgd_pkg::S_BOOT_LD;
      end
      rgd_pkg::S_BOOT_LD: begin
        factor_nxt = rom_q;
        state_nxt  = rgd_pkg::S_IDLE;
      end
      rgd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          sample_nxt = in_ch.sample_in;
          len_nxt    = len_in;
          if (in_ch.block_start) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = rgd_pkg::GAIN_MANUAL;
            step_a_nxt      = step_p;
            state_nxt       = rgd_pkg::S_MAN;
          end else begin
            prod_nxt  = prod_p;
            state_nxt = rgd_pkg::S_OUT;
          end
        end
      end
      rgd_pkg::S_MAN: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = rgd_pkg::GAIN_MANUAL;
        mem_req.wr_data = man_new;
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = rgd_pkg::GAIN_DUCKER;
        man_nxt         = man_new;
        step_b_nxt      = step_p;
        state_nxt       = rgd_pkg::S_DUP;
      end
      rgd_pkg::S_DUP: begin
        step_a_nxt = step_p;
        state_nxt  = rgd_pkg::S_DUK;
      end
      rgd_pkg::S_DUK: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = rgd_pkg::GAIN_DUCKER;
        mem_req.wr_data = duck_new;
        total_nxt       = 25'(man_r) + 25'(duck_new);
        state_nxt       = rgd_pkg::S_IDX;
      end
      rgd_pkg::S_IDX: begin
        rom_rd_en = 1'b1;
        state_nxt = rgd_pkg::S_FAC;
      end
      rgd_pkg::S_FAC: begin
        factor_nxt = rom_q;
        prod_nxt   = prod_p;
        state_nxt  = rgd_pkg::S_OUT;
      end
      rgd_pkg::S_OUT: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          total_gain_nxt = total_r;
          if (shifted > SAT_HI) begin
            sample_out_nxt = 16'sh7FFF;
          end else if (shifted < SAT_LO) begin
            sample_out_nxt = 16'sh8000;
          end else begin
            sample_out_nxt = shifted[15:0];
          end
          state_nxt = rgd_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rgd_pkg::S_BOOT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rgd_pkg::S_BOOT;
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r     <= sample_nxt;
    len_r        <= len_nxt;
    step_a_r     <= step_a_nxt;
    step_b_r     <= step_b_nxt;
    man_r        <= man_nxt;
    factor_r     <= factor_nxt;
    prod_r       <= prod_nxt;
    sample_out_r <= sample_out_nxt;
    total_gain_r <= total_gain_nxt;
  end

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = sample_out_r;
  assign out_ch.total_gain = total_gain_r;

  `RGD_ASSERT_NEXT(a_plain_to_out, clk, rst_n, in_ch.valid && in_ch.ready && !in_ch.block_start, state_r == rgd_pkg::S_OUT, "plain sample did not go to the output stage")
  `RGD_ASSERT_NEXT(a_total_hold, clk, rst_n, state_r != rgd_pkg::S_DUK, $stable(total_r), "total gain changed outside the ducker update")
  `RGD_ASSERT_NEXT(a_out_wait, clk, rst_n, state_r == rgd_pkg::S_OUT && out_valid_r && !out_ch.ready, state_r == rgd_pkg::S_OUT, "result stage overwrote an untaken result")
  `RGD_ASSERT_NOW(a_mem_write, clk, rst_n, mem_req.wr_en, state_r == rgd_pkg::S_MAN || state_r == rgd_pkg::S_DUK, "gain memory written outside an update step")

endmodule

[hdl/ramped_gain_with_ducker.sv]
// Channel   Direction  Payload                                   Transfer when
// in_ch     sink       sample_in, block_start, block_length      valid && ready
// out_ch    source     sample_out, total_gain                    valid && ready
// cfg_*     sink       cfg_index selects, cfg_data written       cfg_we high
//
// A sample without block_start runs the sample multiply in the accept cycle; S_OUT
// then rounds the product and loads the output register.
// A block start sample runs the gain memory read-modify-write of both gains in S_MAN,
// S_DUP and S_DUK (one read port, one step multiplier shared by the three step
// products), the ROM read in S_IDX and the sample multiply in S_FAC ahead of S_OUT.
// After reset, S_BOOT and S_BOOT_LD read the 0 dB word from the ROM before the block
// accepts its first transfer; configuration writes are taken at any time.
// A result waits in the output register while out_ch.ready is low, and the block
// stops before overwriting it; the next input can still be accepted meanwhile.
module ramped_gain_with_ducker #(
  parameter int TABLE_ENTRIES = rgd_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rgd_in_if.sink                         in_ch,
  rgd_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [rgd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  // Configuration registers. Each write keeps only as many low bits of the
  // data as the register holds.
  rgd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.manual_target_gain <= '0;
      cfg_r.ducker_target_gain <= '0;
      cfg_r.mute_enable        <= 1'b0;
      cfg_r.duck_block         <= 1'b0;
      cfg_r.adjust_enable      <= 1'b0;
      cfg_r.manual_fade_step   <= rgd_pkg::FADE_STEP_RST;
      cfg_r.attack_step        <= rgd_pkg::ATTACK_STEP_RST;
      cfg_r.decay_step         <= rgd_pkg::DECAY_STEP_RST;
    end else if (cfg_we) begin
      case (rgd_pkg::cfg_idx_t'(cfg_index))
        rgd_pkg::CFG_MANUAL_TARGET: cfg_r.manual_target_gain <= cfg_data;
        rgd_pkg::CFG_DUCKER_TARGET: cfg_r.ducker_target_gain <= cfg_data;
        rgd_pkg::CFG_MUTE_ENABLE:   cfg_r.mute_enable        <= cfg_data[0];
        rgd_pkg::CFG_DUCK_BLOCK:    cfg_r.duck_block         <= cfg_data[0];
        rgd_pkg::CFG_ADJUST_ENABLE: cfg_r.adjust_enable      <= cfg_data[0];
        rgd_pkg::CFG_FADE_STEP:     cfg_r.manual_fade_step   <= cfg_data[15:0];
        rgd_pkg::CFG_ATTACK_STEP:   cfg_r.attack_step        <= cfg_data[15:0];
        rgd_pkg::CFG_DECAY_STEP:    cfg_r.decay_step         <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // The manual and ducker gains live in a two-entry memory with a registered
  // read; the sequencer reads an entry, ramps it and writes it back.
  rgd_pkg::mem_req_t  mem_req;
  logic signed [23:0] gain_q;

  // The summed gain selects a word of the dB-to-linear ROM, which becomes the
  // Q4.12 factor held for the samples of the block.
  logic               rom_rd_en;
  logic [IDX_W-1:0]   rom_addr;
  logic [15:0]        rom_q;

  rgd_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_req   (mem_req),
    .gain_q    (gain_q),
    .rom_rd_en (rom_rd_en),
    .rom_addr  (rom_addr),
    .rom_q     (rom_q)
  );

  rgd_gain_mem u_gain_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (mem_req),
    .gain_q (gain_q)
  );

  rgd_db_rom #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_db_rom (
    .clk       (clk),
    .rd_en     (rom_rd_en),
    .rd_addr   (rom_addr),
    .rd_data_r (rom_q)
  );

endmodule
